[rtl/vig31_pkg.sv]
package vig31_pkg;

  localparam int unsigned CodeW      = 16;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned PosW       = 4;
  localparam int unsigned LenW       = 4;
  localparam int unsigned KeyLetters = 12;
  localparam int unsigned KeyW       = KeyLetters * IdxW;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = KeyW;

  localparam logic [IdxW-1:0]  AlphaSize     = 5'd31;
  localparam logic [CodeW-1:0] SpaceCode     = 16'h0020;
  localparam logic [CodeW-1:0] LowerA        = 16'h0061;
  localparam logic [CodeW-1:0] LowerZ        = 16'h007A;
  localparam logic [CodeW-1:0] CaseOffset    = 16'h0020;
  localparam logic [LenW-1:0]  KeyLengthRst  = 4'd7;
  localparam logic [LenW-1:0]  KeyLengthMax  = LenW'(KeyLetters);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DECRYPT_MODE = 2'd0,
    CFG_KEY_LETTERS  = 2'd1,
    CFG_KEY_LENGTH   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic             drop;
    logic [CodeW-1:0] out_code;
    logic             was_letter;
  } xform_res_t;

  function automatic logic [CodeW-1:0] alpha_code(input logic [IdxW-1:0] idx);
    logic [CodeW-1:0] c;
    unique case (idx)
      5'd0:  c = 16'h0041;
      5'd1:  c = 16'h0102;
      5'd2:  c = 16'h00C2;
      5'd3:  c = 16'h0042;
      5'd4:  c = 16'h0043;
      5'd5:  c = 16'h0044;
      5'd6:  c = 16'h0045;
      5'd7:  c = 16'h0046;
      5'd8:  c = 16'h0047;
      5'd9:  c = 16'h0048;
      5'd10: c = 16'h0049;
      5'd11: c = 16'h00CE;
      5'd12: c = 16'h004A;
      5'd13: c = 16'h004B;
      5'd14: c = 16'h004C;
      5'd15: c = 16'h004D;
      5'd16: c = 16'h004E;
      5'd17: c = 16'h004F;
      5'd18: c = 16'h0050;
      5'd19: c = 16'h0051;
      5'd20: c = 16'h0052;
      5'd21: c = 16'h0053;
      5'd22: c = 16'h0218;
      5'd23: c = 16'h0054;
      5'd24: c = 16'h021A;
      5'd25: c = 16'h0055;
      5'd26: c = 16'h0056;
      5'd27: c = 16'h0057;
      5'd28: c = 16'h0058;
      5'd29: c = 16'h0059;
      5'd30: c = 16'h005A;
      default: c = 16'h0041;
    endcase
    return c;
  endfunction

endpackage

[rtl/vig31_in_if.sv]
interface vig31_in_if;
  logic                        valid;
  logic                        ready;
  logic [vig31_pkg::CodeW-1:0] char_code;
  logic                        message_start;

  modport source (output valid, output char_code, output message_start, input ready);
  modport sink   (input valid, input char_code, input message_start, output ready);
endinterface

[rtl/vig31_out_if.sv]
interface vig31_out_if;
  logic                        valid;
  logic                        ready;
  logic [vig31_pkg::CodeW-1:0] out_code;
  logic                        was_letter;

  modport source (output valid, output out_code, output was_letter, input ready);
  modport sink   (input valid, input out_code, input was_letter, output ready);
endinterface

[rtl/vig31_key.sv]
module vig31_key (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        message_start_i,
  input  logic [vig31_pkg::KeyW-1:0]  key_letters_i,
  input  logic [vig31_pkg::LenW-1:0]  key_length_i,
  output logic [vig31_pkg::IdxW-1:0]  shift_o
);

  logic [vig31_pkg::PosW-1:0] pos_q, pos_d;
  logic [vig31_pkg::PosW-1:0] pos;
  logic [vig31_pkg::PosW-1:0] pos_inc;
  logic [vig31_pkg::LenW-1:0] len;
  logic [vig31_pkg::IdxW-1:0] letter [vig31_pkg::KeyLetters];
  logic [vig31_pkg::IdxW-1:0] raw;

  for (genvar g = 0; g < vig31_pkg::KeyLetters; g++) begin : g_letter
    assign letter[g] = key_letters_i[g*vig31_pkg::IdxW +: vig31_pkg::IdxW];
  end

  always_comb begin
    priority if (key_length_i == '0) begin
      len = vig31_pkg::LenW'(1);
    end else if (key_length_i > vig31_pkg::KeyLengthMax) begin
      len = vig31_pkg::KeyLengthMax;
    end else begin
      len = key_length_i;
    end
  end

  always_comb begin
    pos = message_start_i ? '0 : pos_q;
    // a stale position after the length was lowered restarts at letter 0
    if (pos >= len) begin
      pos = '0;
    end
    pos_inc = pos + vig31_pkg::PosW'(1);
    pos_d   = pos_q;
    if (accept_i) begin
      pos_d = (pos_inc >= len) ? '0 : pos_inc;
    end
  end

  // letter index 31 folds to 0
  assign raw     = letter[pos];
  assign shift_o = (raw == vig31_pkg::AlphaSize) ? '0 : raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

[rtl/vig31_xform.sv]
module vig31_xform (
  input  logic [vig31_pkg::CodeW-1:0] char_code_i,
  input  logic [vig31_pkg::IdxW-1:0]  shift_i,
  input  logic                        decrypt_i,
  output vig31_pkg::xform_res_t       res_o
);

  logic [vig31_pkg::CodeW-1:0] code;
  logic                        found;
  logic [vig31_pkg::IdxW-1:0]  idx;
  logic [vig31_pkg::IdxW:0]    sum;
  logic [vig31_pkg::IdxW:0]    sum_red;
  logic [vig31_pkg::IdxW-1:0]  res_idx;

  always_comb begin
    code = char_code_i;
    if (char_code_i >= vig31_pkg::LowerA && char_code_i <= vig31_pkg::LowerZ) begin
      code = char_code_i - vig31_pkg::CaseOffset;
    end
  end

  // alphabet codes are distinct, so at most one entry hits
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < int'(vig31_pkg::AlphaSize); i++) begin
      if (vig31_pkg::alpha_code(vig31_pkg::IdxW'(i)) == code) begin
        found = 1'b1;
        idx   = vig31_pkg::IdxW'(i);
      end
    end
  end

  always_comb begin
    if (decrypt_i) begin
      sum = {1'b0, idx} + {1'b0, vig31_pkg::AlphaSize} - {1'b0, shift_i};
    end else begin
      sum = {1'b0, idx} + {1'b0, shift_i};
    end
    // sum stays below twice the alphabet size
    sum_red = (sum >= {1'b0, vig31_pkg::AlphaSize}) ? sum - {1'b0, vig31_pkg::AlphaSize} : sum;
    res_idx = sum_red[vig31_pkg::IdxW-1:0];
  end

  always_comb begin
    res_o.drop       = (code == vig31_pkg::SpaceCode);
    res_o.was_letter = found;
    res_o.out_code   = found ? vig31_pkg::alpha_code(res_idx) : code;
  end

endmodule

[rtl/vigenere_cipher_31_letter_core.sv]
// An accepted word is registered in stage 1 and its result in the output register.
// Throughput: one word per cycle unless out_o.ready stalls; the key counter steps
// per word and the mod-31 adder is combinational, so words stream back to back.
// Reset: rst_ni clears both stage valids, the key position, decrypt mode and the
// key letters, and sets the key length to 7.
module vigenere_cipher_31_letter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vig31_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vig31_pkg::CfgDataW-1:0]  cfg_data_i,
  vig31_in_if.sink                        in_i,
  vig31_out_if.source                     out_o
);

  logic                        decrypt_q;
  logic [vig31_pkg::KeyW-1:0]  key_letters_q;
  logic [vig31_pkg::LenW-1:0]  key_length_q;

  logic                        s1_valid_q;
  logic [vig31_pkg::CodeW-1:0] s1_code_q;
  logic [vig31_pkg::IdxW-1:0]  s1_shift_q;
  logic                        out_valid_q;
  logic [vig31_pkg::CodeW-1:0] out_code_q;
  logic                        out_letter_q;

  logic                        in_acc;
  logic                        out_load_ok;
  logic                        s1_adv;
  logic                        out_load;
  logic [vig31_pkg::IdxW-1:0]  shift;
  vig31_pkg::xform_res_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q     <= 1'b0;
      key_letters_q <= '0;
      key_length_q  <= vig31_pkg::KeyLengthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vig31_pkg::CFG_DECRYPT_MODE: decrypt_q     <= cfg_data_i[0];
        vig31_pkg::CFG_KEY_LETTERS:  key_letters_q <= cfg_data_i[vig31_pkg::KeyW-1:0];
        vig31_pkg::CFG_KEY_LENGTH:   key_length_q  <= cfg_data_i[vig31_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  vig31_key u_key (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_acc),
    .message_start_i (in_i.message_start),
    .key_letters_i   (key_letters_q),
    .key_length_i    (key_length_q),
    .shift_o         (shift)
  );

  vig31_xform u_xform (
    .char_code_i (s1_code_q),
    .shift_i     (s1_shift_q),
    .decrypt_i   (decrypt_q),
    .res_o       (res)
  );

  // spaces leave stage 1 without needing the output register
  assign out_load_ok = !out_valid_q || out_o.ready;
  assign s1_adv      = s1_valid_q && (res.drop || out_load_ok);
  assign out_load    = s1_valid_q && !res.drop && out_load_ok;
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign in_acc      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_code_q  <= in_i.char_code;
      s1_shift_q <= shift;
    end
    if (out_load) begin
      out_code_q   <= res.out_code;
      out_letter_q <= res.was_letter;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_code   = out_code_q;
  assign out_o.was_letter = out_letter_q;

endmodule

[sim/vigenere_cipher_31_letter_checker.sv]
`timescale 1ns / 100ps

module vigenere_cipher_31_letter_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vig31_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vig31_pkg::CfgDataW-1:0] cfg_data_i,
  vig31_in_if                            char_in_i,
  vig31_out_if                           char_out_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_o
);

  typedef struct packed {
    logic [vig31_pkg::CodeW-1:0] code;
    logic                        letter;
  } cipher_word_t;

  // Code points of the 31 letters, index 0 in the lowest 16 bits.
  localparam logic [31*vig31_pkg::CodeW-1:0] AlphaTable = {
    16'h005A, 16'h0059, 16'h0058, 16'h0057, 16'h0056, 16'h0055, 16'h021A, 16'h0054,
    16'h0218, 16'h0053, 16'h0052, 16'h0051, 16'h0050, 16'h004F, 16'h004E, 16'h004D,
    16'h004C, 16'h004B, 16'h004A, 16'h00CE, 16'h0049, 16'h0048, 16'h0047, 16'h0046,
    16'h0045, 16'h0044, 16'h0043, 16'h0042, 16'h00C2, 16'h0102, 16'h0041
  };

  localparam int AlphaN = int'(vig31_pkg::AlphaSize);

  logic                       dec_mode;
  logic [vig31_pkg::KeyW-1:0] key_bits;
  logic [vig31_pkg::LenW-1:0] key_len_q;
  logic [vig31_pkg::PosW-1:0] key_pos;

  cipher_word_t expected_chars [$];

  // Returns 1 when the character yields an output word; advances the key position.
  function automatic logic cipher_char(input logic [vig31_pkg::CodeW-1:0] code_in,
                                       input logic start, output cipher_word_t word);
    int len;
    int pos;
    int nxt;
    int shift;
    int idx;
    int r;
    int i;
    logic [vig31_pkg::CodeW-1:0] c;
    len = int'(key_len_q);
    if (len == 0) len = 1;
    if (len > int'(vig31_pkg::KeyLengthMax)) len = int'(vig31_pkg::KeyLengthMax);
    pos = start ? 0 : int'(key_pos);
    // a position left over from a longer key falls back to key letter 0
    if (pos >= len) pos = 0;
    shift = int'(key_bits[vig31_pkg::IdxW*pos +: vig31_pkg::IdxW]);
    if (shift >= AlphaN) shift = shift - AlphaN;
    nxt = pos + 1;
    if (nxt >= len) nxt = 0;
    key_pos = vig31_pkg::PosW'(nxt);

    c = code_in;
    if (c >= vig31_pkg::LowerA && c <= vig31_pkg::LowerZ) c = c - vig31_pkg::CaseOffset;
    word.code   = c;
    word.letter = 1'b0;
    if (c == vig31_pkg::SpaceCode) return 1'b0;

    idx = -1;
    for (i = 0; i < AlphaN; i++) begin
      if (AlphaTable[vig31_pkg::CodeW*i +: vig31_pkg::CodeW] == c) idx = i;
    end
    if (idx >= 0) begin
      r = dec_mode ? (idx + AlphaN - shift) % AlphaN : (idx + shift) % AlphaN;
      word.code   = AlphaTable[vig31_pkg::CodeW*r +: vig31_pkg::CodeW];
      word.letter = 1'b1;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_word_t exp_w;
    cipher_word_t got_w;
    if (!rst_ni) begin
      dec_mode         = 1'b0;
      key_bits         = '0;
      key_len_q        = vig31_pkg::KeyLengthRst;
      key_pos          = '0;
      mismatch_count_o = 0;
      expected_chars.delete();
      pending_o        = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          vig31_pkg::CFG_DECRYPT_MODE: dec_mode  = cfg_data_i[0];
          vig31_pkg::CFG_KEY_LETTERS:  key_bits  = cfg_data_i[vig31_pkg::KeyW-1:0];
          vig31_pkg::CFG_KEY_LENGTH:   key_len_q = cfg_data_i[vig31_pkg::LenW-1:0];
          default: ;
        endcase
      end

      if (char_in_i.valid && char_in_i.ready) begin
        if (cipher_char(char_in_i.char_code, char_in_i.message_start, exp_w)) begin
          expected_chars.push_back(exp_w);
        end
      end

      if (char_out_i.valid && char_out_i.ready) begin
        got_w.code   = char_out_i.out_code;
        got_w.letter = char_out_i.was_letter;
        if (expected_chars.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("%0t: unexpected word: code %h letter %b", $realtime,
                     got_w.code, got_w.letter);
          end
          mismatch_count_o++;
        end else begin
          exp_w = expected_chars.pop_front();
          if (exp_w.code != got_w.code || exp_w.letter != got_w.letter) begin
            if (mismatch_count_o < 10) begin
              $display("%0t: word mismatch: expected code %h letter %b, got code %h letter %b",
                       $realtime, exp_w.code, exp_w.letter, got_w.code, got_w.letter);
            end
            mismatch_count_o++;
          end
        end
      end
      pending_o = expected_chars.size();
    end
  end

endmodule

[sim/vigenere_cipher_31_letter_core_tb.sv]
`timescale 1ns / 100ps

module vigenere_cipher_31_letter_core_tb;

  localparam logic        ModeEncrypt   = 1'b0;
  localparam logic        ModeDecrypt   = 1'b1;
  localparam int          SettleCycles  = 4;
  localparam int          HoldCycles    = 200;
  localparam int          IdleLimit     = 4000;
  localparam int          NumPhases     = 7;
  localparam int          CharsPerPhase = 100;

  // entries 0..11: 3 30 31 1 15 0 22 7 11 24 2 29
  localparam logic [vig31_pkg::KeyW-1:0] DirKey = {
    5'd29, 5'd2, 5'd24, 5'd11, 5'd7, 5'd22, 5'd0, 5'd15, 5'd1, 5'd31, 5'd30, 5'd3
  };

  // first entry in the top bits
  localparam logic [16*vig31_pkg::CodeW-1:0] DirChars = {
    16'h0041, 16'h005A, 16'h0102, 16'h00C2, 16'h021A, 16'h0218, 16'h0061, 16'h007A,
    16'h0020, 16'h0000, 16'hFFFF, 16'h0060, 16'h007B, 16'h00E2, 16'h0040, 16'h005B
  };
  localparam logic [6*vig31_pkg::CodeW-1:0] DirDecChars = {
    16'h005A, 16'h0041, 16'h021A, 16'h0071, 16'h0020, 16'h0042
  };

  localparam logic [5*vig31_pkg::CodeW-1:0] RoUpper = {
    16'h021A, 16'h0218, 16'h00CE, 16'h00C2, 16'h0102
  };
  localparam logic [5*vig31_pkg::CodeW-1:0] RoLower = {
    16'h021B, 16'h0219, 16'h00EE, 16'h00E2, 16'h0103
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [vig31_pkg::CfgIdxW-1:0]  cfg_index;
  logic [vig31_pkg::CfgDataW-1:0] cfg_data;

  int unsigned mismatches;
  int unsigned pending;
  logic        calm;
  logic        hold_req;

  vig31_in_if  char_in ();
  vig31_out_if char_out ();

  vigenere_cipher_31_letter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (char_in),
    .out_o       (char_out)
  );

  vigenere_cipher_31_letter_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .char_in_i        (char_in),
    .char_out_i       (char_out),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [vig31_pkg::CodeW-1:0] rand_char();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return vig31_pkg::CodeW'($urandom_range(16'h0041, 16'h005A));
    if (sel < 50) return vig31_pkg::CodeW'($urandom_range(16'h0061, 16'h007A));
    if (sel < 60) return RoUpper[vig31_pkg::CodeW*$urandom_range(0, 4) +: vig31_pkg::CodeW];
    if (sel < 72) return vig31_pkg::SpaceCode;
    if (sel < 77) return RoLower[vig31_pkg::CodeW*$urandom_range(0, 4) +: vig31_pkg::CodeW];
    if (sel < 90) return vig31_pkg::CodeW'($urandom_range(0, 16'hFFFF));
    return vig31_pkg::CodeW'($urandom_range(0, 16'h007F));
  endfunction

  function automatic logic [vig31_pkg::KeyW-1:0] rand_key();
    logic [vig31_pkg::KeyW-1:0] k;
    int i;
    for (i = 0; i < vig31_pkg::KeyLetters; i++) begin
      k[vig31_pkg::IdxW*i +: vig31_pkg::IdxW] = ($urandom_range(0, 15) == 0) ?
          5'd31 : vig31_pkg::IdxW'($urandom_range(0, 30));
    end
    return k;
  endfunction

  task automatic send_char(input logic [vig31_pkg::CodeW-1:0] code, input logic start);
    char_in.valid         <= 1'b1;
    char_in.char_code     <= code;
    char_in.message_start <= start;
    @(posedge clk_i);
    while (!char_in.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      char_in.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
  endtask

  // Hold the input until every expected word is out, then wait SettleCycles so spaces still in the pipe clear.
  task automatic drain_results();
    char_in.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic load_key(input logic mode, input logic [vig31_pkg::KeyW-1:0] key,
                          input logic [vig31_pkg::LenW-1:0] len);
    cfg_we    <= 1'b1;
    cfg_index <= vig31_pkg::CFG_DECRYPT_MODE;
    cfg_data  <= vig31_pkg::CfgDataW'(mode);
    @(negedge clk_i);
    cfg_index <= vig31_pkg::CFG_KEY_LETTERS;
    cfg_data  <= vig31_pkg::CfgDataW'(key);
    @(negedge clk_i);
    cfg_index <= vig31_pkg::CFG_KEY_LENGTH;
    cfg_data  <= vig31_pkg::CfgDataW'(len);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    char_out.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        char_out.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        char_out.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        char_out.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        char_out.ready <= 1'b1;
      end else begin
        char_out.ready <= 1'b1;
      end
    end
  end

  // watchdog: end the run after too many cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((char_in.valid && char_in.ready) || (char_out.valid && char_out.ready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int i;
    int phase;
    int sent;
    int msg_len;
    int j;
    logic noisy;
    logic start;
    logic mode;
    logic [vig31_pkg::KeyW-1:0] key;
    logic [vig31_pkg::LenW-1:0] len;

    calm                  = 1'b0;
    hold_req              = 1'b0;
    rst_ni                <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= vig31_pkg::CFG_DECRYPT_MODE;
    cfg_data              <= '0;
    char_in.valid         <= 1'b0;
    char_in.char_code     <= '0;
    char_in.message_start <= 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes of the code space, folding, space and pass-through
    load_key(ModeEncrypt, DirKey, 4'd7);
    for (i = 15; i >= 0; i--) begin
      send_char(DirChars[vig31_pkg::CodeW*i +: vig31_pkg::CodeW], i == 15);
    end
    drain_results();
    load_key(ModeDecrypt, DirKey, vig31_pkg::KeyLengthMax);
    for (i = 5; i >= 0; i--) begin
      send_char(DirDecChars[vig31_pkg::CodeW*i +: vig31_pkg::CodeW], i == 5);
    end
    drain_results();
    // zero length with a stale position, then length beyond the maximum
    load_key(ModeDecrypt, DirKey, 4'd0);
    send_char(16'h0041, 1'b0);
    send_char(16'h0041, 1'b0);
    drain_results();
    load_key(ModeEncrypt, '1, 4'd15);
    send_char(16'h004D, 1'b0);
    send_char(16'h004E, 1'b0);

    for (phase = 0; phase < NumPhases; phase++) begin
      drain_results();
      calm = (phase == NumPhases - 1);
      case (phase)
        0: begin mode = ModeEncrypt; key = rand_key(); len = 4'd7; end
        1: begin mode = ModeDecrypt; key = '1; len = vig31_pkg::KeyLengthMax; end
        3: begin mode = ModeEncrypt; key = '0; len = vig31_pkg::KeyLengthMax; end
        4: begin mode = ModeDecrypt; key = rand_key(); len = 4'd7; end
        5: begin
          mode = 1'($urandom_range(0, 1));
          key  = rand_key();
          len  = vig31_pkg::LenW'($urandom_range(0, 15));
        end
        default: begin
          mode = 1'($urandom_range(0, 1));
          key  = rand_key();
          len  = vig31_pkg::LenW'($urandom_range(7, 12));
        end
      endcase
      load_key(mode, key, len);

      sent = 0;
      while (sent < CharsPerPhase) begin
        msg_len = $urandom_range(1, 40);
        noisy   = ($urandom_range(0, 9) == 0);
        for (j = 0; j < msg_len; j++) begin
          start = noisy ? ($urandom_range(0, 31) == 0) : (j == 0);
          if (phase == 2 && sent == 30) hold_req = 1'b1;
          if (phase == 4 && sent == 50) drain_results();
          send_char(rand_char(), start);
          sent++;
        end
      end
    end

    char_in.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2 * SettleCycles) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
rtl/vig31_pkg.sv
rtl/vig31_in_if.sv
rtl/vig31_out_if.sv
rtl/vig31_key.sv
rtl/vig31_xform.sv
rtl/vigenere_cipher_31_letter_core.sv
sim/vigenere_cipher_31_letter_checker.sv
sim/vigenere_cipher_31_letter_core_tb.sv
